FILE: src/srd_pkg.sv
// Shared types and constants for the slot allocator with reuse delay.
// Used by srd_ctrl and the top level; srd_ram is generic and does not import it.
package srd_pkg;

	localparam int MAX_SLOTS = 1024;
	localparam int SLOT_W    = $clog2(MAX_SLOTS);
	localparam int TOP_W     = $clog2(MAX_SLOTS + 1);

	// Widths of the item fields and registers.
	localparam int IDX_W    = 10;
	localparam int TIME_W   = 32;
	localparam int RSV_W    = 7;
	localparam int MS_W     = 16;
	localparam int STATUS_W = 2;

	// Compare width for slot numbers: wide enough for the used top, for a
	// slot index item field and for the reserved count plus one.
	localparam int CMP_W = (TOP_W > IDX_W) ? TOP_W : IDX_W;

	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = MS_W;

	localparam logic [MS_W-1:0] GRACE_RESET = 16'd2000;
	localparam logic [MS_W-1:0] DELAY_RESET = 16'd500;

	typedef enum logic [CFG_ADDR_W-1:0] {
		CFG_RESERVED = 2'd0,
		CFG_GRACE    = 2'd1,
		CFG_DELAY    = 2'd2
	} cfg_index_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_BAD  = 2'd2
	} status_t;

	typedef enum logic {
		REQ_ALLOC = 1'b0,
		REQ_FREE  = 1'b1
	} req_t;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic              free;
		logic [TIME_W-1:0] stamp;
	} slot_entry_t;

	typedef struct packed {
		logic [RSV_W-1:0] reserved_count;
		logic [MS_W-1:0]  startup_grace_ms;
		logic [MS_W-1:0]  reuse_delay_ms;
	} cfg_t;

	typedef struct packed {
		req_t              req_type;
		logic [IDX_W-1:0]  slot_index;
		logic [TIME_W-1:0] now_time;
	} request_t;

	typedef struct packed {
		status_t          status;
		logic [IDX_W-1:0] slot;
		logic             grew;
	} result_t;

endpackage

FILE: src/slot_allocator_reuse_delay_unit.sv
// Slot allocator with reuse delay. After reset a clearing pass over all
// MAX_SLOTS (1024) slot entries runs before the first item is taken;
// configuration writes are taken at any time. A free item's result is registered
// in the controller when it is accepted and then passes to the output register.
// An allocate item evaluates one slot entry per cycle from the slot memory, from
// reserved_count + 1 up to just below the used top, and stops at the first
// reusable slot; when all used slots miss it appends the slot at the used top or
// at reserved_count + 1, whichever is higher, or reports full. Its result is
// registered in the controller when the scan ends. The controller is ready for
// the next item in the cycle after a result passes to the output register. A
// result that finds the output register full waits in the controller until it
// drains. One item is worked on at a time; a new item is taken while the last
// result waits in the output register. Depends on srd_pkg, srd_ctrl and srd_ram.
module slot_allocator_reuse_delay_unit
	import srd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [47:0]           s_tdata,  // slot_index[9:0], now_time[41:10], zero
	input  logic [0:0]            s_tuser,  // req_type[0]
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [15:0]           m_tdata   // status[1:0], slot[11:2], grew[12], zero
);

	cfg_t     cfg_q;
	request_t req;
	result_t  res, out_q;
	logic     res_valid, res_space, out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{reserved_count: '0, startup_grace_ms: GRACE_RESET,
				reuse_delay_ms: DELAY_RESET};
		end else if (cfg_we) begin
			case (cfg_index_t'(cfg_addr))
				CFG_RESERVED: cfg_q.reserved_count   <= cfg_wdata[RSV_W-1:0];
				CFG_GRACE:    cfg_q.startup_grace_ms <= cfg_wdata;
				CFG_DELAY:    cfg_q.reuse_delay_ms   <= cfg_wdata;
				default:      cfg_q <= cfg_q;
			endcase
		end
	end

	assign req.req_type   = req_t'(s_tuser[0]);
	assign req.slot_index = s_tdata[IDX_W-1:0];
	assign req.now_time   = s_tdata[IDX_W+TIME_W-1:IDX_W];

	// The output register takes a result when empty or when drained this cycle.
	assign res_space = !out_valid_q || m_tready;

	srd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.req_valid(s_tvalid),
		.req_ready(s_tready),
		.req      (req),
		.res_space(res_space),
		.res_valid(res_valid),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, out_q.grew, out_q.slot, out_q.status};

endmodule

FILE: src/srd_ram.sv
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered. No dependencies.
module srd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: src/srd_ctrl.sv
// Sequencer of the slot allocator: clearing pass, free stamping and the
// allocate scan over the slot memory. Depends on srd_pkg and srd_ram.
module srd_ctrl
	import srd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  logic     req_valid,
	output logic     req_ready,
	input  request_t req,
	input  logic     res_space,
	output logic     res_valid,
	output result_t  res
);

	state_t                    state_q, state_d;
	logic [SLOT_W-1:0]         clr_q;
	logic [TOP_W-1:0]          used_top_q;
	logic [CMP_W-1:0]          issue_q;
	logic                      pend_s1;
	logic [SLOT_W-1:0]         pend_addr_s1;
	logic [TIME_W-1:0]         now_q;
	result_t                   res_q;

	logic                      ram_we, ram_re;
	logic [SLOT_W-1:0]         ram_waddr, ram_raddr;
	slot_entry_t               ram_wdata, rd_entry;
	logic [$bits(slot_entry_t)-1:0] ram_rdata;

	logic [CMP_W-1:0]          first, top_ext, append_s;
	logic                      accept, free_ok, first_in, issue_in, full, hit, clr_last;
	logic [TIME_W:0]           elapsed;
	logic                      grace_ok, delay_ok;

	always_comb begin
		first    = CMP_W'(cfg.reserved_count) + CMP_W'(1);
		top_ext  = CMP_W'(used_top_q);
		accept   = req_valid && req_ready;
		free_ok  = CMP_W'(req.slot_index) < top_ext;
		first_in = first < top_ext;
		issue_in = issue_q < top_ext;
		append_s = (top_ext > first) ? top_ext : first;
		full     = append_s >= CMP_W'(MAX_SLOTS);
		clr_last = clr_q == SLOT_W'(MAX_SLOTS - 1);

		rd_entry = slot_entry_t'(ram_rdata);
		// A borrow means the clock went backwards.
		elapsed  = {1'b0, now_q} - {1'b0, rd_entry.stamp};
		grace_ok = rd_entry.stamp < TIME_W'(cfg.startup_grace_ms);
		delay_ok = !elapsed[TIME_W] &&
			(elapsed[TIME_W-1:0] > TIME_W'(cfg.reuse_delay_ms));
		hit      = pend_s1 && rd_entry.free && (grace_ok || delay_ok);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (accept) state_d = (req.req_type == REQ_FREE) ? S_FINISH : S_SCAN;
			end
			S_SCAN: begin
				if (hit || !pend_s1) state_d = S_FINISH;
			end
			S_FINISH: begin
				if (res_space) state_d = S_IDLE;
			end
			default: state_d = S_CLEAR;
		endcase
	end

	// Outputs and memory port control.
	always_comb begin
		req_ready = 1'b0;
		res_valid = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = '0;
		case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
			end
			S_IDLE: begin
				req_ready = 1'b1;
				if (accept && req.req_type == REQ_FREE) begin
					ram_we    = free_ok;
					ram_waddr = SLOT_W'(req.slot_index);
					ram_wdata = '{free: 1'b1, stamp: req.now_time};
				end else if (accept) begin
					ram_re    = first_in;
					ram_raddr = SLOT_W'(first);
				end
			end
			S_SCAN: begin
				ram_re    = issue_in;
				ram_raddr = SLOT_W'(issue_q);
				if (hit) begin
					ram_we    = 1'b1;
					ram_waddr = pend_addr_s1;
				end else if (!pend_s1 && !full) begin
					ram_we    = 1'b1;
					ram_waddr = SLOT_W'(append_s);
				end
			end
			S_FINISH: begin
				res_valid = res_space;
			end
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_q      <= '0;
			used_top_q <= '0;
			pend_s1    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + SLOT_W'(1);
			end
			if (state_q == S_IDLE && accept) begin
				pend_s1 <= (req.req_type == REQ_ALLOC) && first_in;
			end else if (state_q == S_SCAN) begin
				pend_s1 <= (state_d == S_SCAN) && issue_in;
			end
			if (state_q == S_SCAN && !hit && !pend_s1 && !full) begin
				used_top_q <= TOP_W'(append_s + CMP_W'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && accept) begin
			now_q        <= req.now_time;
			issue_q      <= first + CMP_W'(1);
			pend_addr_s1 <= SLOT_W'(first);
			if (free_ok) begin
				res_q <= '{status: ST_OK, slot: req.slot_index, grew: 1'b0};
			end else begin
				res_q <= '{status: ST_BAD, slot: '0, grew: 1'b0};
			end
		end else if (state_q == S_SCAN) begin
			if (issue_in) begin
				issue_q <= issue_q + CMP_W'(1);
			end
			pend_addr_s1 <= SLOT_W'(issue_q);
			if (hit) begin
				res_q <= '{status: ST_OK, slot: IDX_W'(pend_addr_s1), grew: 1'b0};
			end else if (!pend_s1 && full) begin
				res_q <= '{status: ST_FULL, slot: '0, grew: 1'b0};
			end else if (!pend_s1) begin
				res_q <= '{status: ST_OK, slot: IDX_W'(append_s), grew: 1'b1};
			end
		end
	end

	assign res = res_q;

	srd_ram #(
		.WIDTH($bits(slot_entry_t)),
		.DEPTH(MAX_SLOTS)
	) u_slot_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// A slot under evaluation always lies inside the used region.
	a_pend_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && pend_s1) |-> (CMP_W'(pend_addr_s1) < top_ext))
		else $error("scan evaluates a slot above the used top");

	// The scan declares a miss only after every used slot has been issued.
	a_miss_complete: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && !pend_s1) |-> (issue_q >= top_ext))
		else $error("scan ended before reaching the used top");

	// The used region only grows.
	a_top_monotone: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (used_top_q >= $past(used_top_q)))
		else $error("used top shrank");

	// The clearing pass covers the whole memory before items are taken.
	a_clear_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR && state_d == S_IDLE) |-> clr_last)
		else $error("clearing pass left early");

endmodule
